@@ sv/nrtc_pkg.sv @@
package nrtc_pkg;

    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 6;
    localparam int DIGITS_W   = DIGIT_W * NUM_DIGITS;

    // Default depth of the line queue between front and back; must be 2 or more
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [HOUR_W-1:0] HOUR_OFFSET_RST = 5'd8;

    // Line verdict codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_GPRMC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM    = 2'd3;

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // One finished line handed from front to back
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIGITS_W-1:0] digits;
    } line_rec_t;

    // Expected header text "$GPRMC", one character per position
    function automatic logic [CHAR_W-1:0] header_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] ch);
        return is_digit(ch) || ((ch >= CH_A) && (ch <= CH_F));
    endfunction

    // Nibble value of an uppercase hex digit; meaningless when is_hex is false
    function automatic logic [DIGIT_W-1:0] hex_val(input logic [CHAR_W-1:0] ch);
        logic [DIGIT_W-1:0] v;
        if (is_digit(ch))
        begin
            v = ch[DIGIT_W-1:0];
        end
        else
        begin
            v = DIGIT_W'(ch[DIGIT_W-1:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

@@ sv/nrtc_if.sv @@
interface nrtc_char_if import nrtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_line;

    modport source (output valid, char_in, end_of_line, input ready);
    modport sink   (input valid, char_in, end_of_line, output ready);
endinterface

interface nrtc_result_if import nrtc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] line_status;
    logic                have_time;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [MIN_W-1:0]    seconds;

    modport source (output valid, line_status, have_time, hours, minutes, seconds,
                    input ready);
    modport sink   (input valid, line_status, have_time, hours, minutes, seconds,
                    output ready);
endinterface

@@ sv/nmea_rmc_time_checker.sv @@
// NMEA RMC line checker with local-time conversion.
// Input channel "chars": one beat per ASCII character of a sentence line; end_of_line
//   marks the last character. Output channel "result": one beat per line, carrying
//   the verdict (accepted, not GPRMC, status not A, checksum mismatch) and the most
//   recently accepted time (hour shifted by the offset register modulo 24, minutes
//   and seconds clamped to 59), with have_time set once any line has been accepted.
// Configuration: cfg_wr_en/cfg_wr_data write the 5-bit hour offset (reset value 8);
//   write it only while no line is in flight.
// Throughput: one character per cycle while the line queue has room. Each character
//   only touches a handful of small per-line registers in the front end.
// Result path: a line enters the queue when its end-of-line character is accepted,
//   then moves into the output register once that register is empty or its beat is
//   taken; the result beat is valid from then on.
// Reset: rst_n clears all per-line state, the line queue, the held time and the
//   output register, and reloads the hour offset; nothing sweeps any memory.
// Receiver stall: the output register holds its beat; finished lines collect in the
//   line queue (QUEUE_DEPTH entries, 2 or more), and chars.ready drops only when
//   that queue is full, so characters keep flowing through a short stall.
module nmea_rmc_time_checker import nrtc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [HOUR_W-1:0] cfg_wr_data,
    nrtc_char_if.sink         chars,
    nrtc_result_if.source     result
);

    // front end: character classification and per-line bookkeeping
    logic      q_push;
    logic      q_full;
    line_rec_t q_push_rec;

    // back end: time conversion and the output beat
    logic      q_pop;
    logic      q_not_empty;
    line_rec_t q_pop_rec;

    nrtc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_full (q_full),
        .q_push (q_push),
        .q_rec  (q_push_rec)
    );

    // Hold finished lines here so the character side waits on the result side only when the queue is full
    nrtc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_rec   (q_pop_rec)
    );

    nrtc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_not_empty (q_not_empty),
        .q_rec       (q_pop_rec),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

@@ sv/nrtc_front.sv @@
module nrtc_front import nrtc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    nrtc_char_if.sink       chars,
    input  logic            q_full,
    output logic            q_push,
    output line_rec_t       q_rec
);

    localparam logic [7:0] POS_HDR_END   = 8'd6;
    localparam logic [7:0] POS_SHORT     = 8'd5;
    localparam logic [7:0] POS_TIME      = 8'd7;
    localparam logic [7:0] POS_MAX       = 8'd255;

    logic [7:0]          pos_reg,     pos_next;
    logic [1:0]          comma_reg,   comma_next;
    logic                hdr_ok_reg,  hdr_ok_next;
    logic                active_reg,  active_next;
    logic [CHAR_W-1:0]   xor_reg,     xor_next;
    logic                star_reg,    star_next;
    logic [CHAR_W-1:0]   prev_reg,    prev_next;
    logic [DIGITS_W-1:0] digits_reg,  digits_next;

    logic                accept;
    logic [CHAR_W-1:0]   c;
    logic                sum_ok;

    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.char_in;

    always_comb
    begin
        hdr_ok_next = hdr_ok_reg;
        if (pos_reg < POS_HDR_END)
        begin
            if (c != header_char(pos_reg[2:0]))
            begin
                hdr_ok_next = 1'b0;
            end
        end
        else if (pos_reg == POS_HDR_END)
        begin
            if (c != CH_COMMA)
            begin
                hdr_ok_next = 1'b0;
            end
        end

        comma_next  = comma_reg;
        active_next = active_reg;
        if (comma_reg == 2'd2)
        begin
            active_next = (c == CH_A);
            comma_next  = 2'd3;
        end
        else if ((c == CH_COMMA) && (comma_reg < 2'd2))
        begin
            comma_next = comma_reg + 2'd1;
        end

        xor_next  = xor_reg;
        star_next = star_reg;
        if ((pos_reg != '0) && !star_reg)
        begin
            if (c == CH_STAR)
            begin
                star_next = 1'b1;
            end
            else
            begin
                xor_next = xor_reg ^ c;
            end
        end

        prev_next = c;

        digits_next = digits_reg;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (pos_reg == POS_TIME + 8'(k))
            begin
                digits_next[DIGIT_W*k +: DIGIT_W] = is_digit(c) ? c[DIGIT_W-1:0] : '0;
            end
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;

        sum_ok = star_next && (pos_reg != '0) && is_hex(prev_reg) && is_hex(c)
                 && ({hex_val(prev_reg), hex_val(c)} == xor_next);

        if (!hdr_ok_next || (pos_reg < POS_SHORT))
        begin
            q_rec.status = ST_NOT_GPRMC;
        end
        else if (!active_next)
        begin
            q_rec.status = ST_NOT_ACTIVE;
        end
        else if (!sum_ok)
        begin
            q_rec.status = ST_BAD_SUM;
        end
        else
        begin
            q_rec.status = ST_OK;
        end
        q_rec.digits = digits_next;
    end

    assign q_push = accept && chars.end_of_line;

    // Advance per-line state on every character; drop it back to idle at end of line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            comma_reg  <= '0;
            hdr_ok_reg <= 1'b1;
            active_reg <= 1'b0;
            xor_reg    <= '0;
            star_reg   <= 1'b0;
            prev_reg   <= '0;
            digits_reg <= '0;
        end
        else if (accept)
        begin
            if (chars.end_of_line)
            begin
                pos_reg    <= '0;
                comma_reg  <= '0;
                hdr_ok_reg <= 1'b1;
                active_reg <= 1'b0;
                xor_reg    <= '0;
                star_reg   <= 1'b0;
                prev_reg   <= '0;
                digits_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                comma_reg  <= comma_next;
                hdr_ok_reg <= hdr_ok_next;
                active_reg <= active_next;
                xor_reg    <= xor_next;
                star_reg   <= star_next;
                prev_reg   <= prev_next;
                digits_reg <= digits_next;
            end
        end
    end

endmodule

@@ sv/nrtc_queue.sv @@
module nrtc_queue import nrtc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output line_rec_t pop_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    line_rec_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("line queue count beyond depth");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("line pushed into full queue");
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("line popped from empty queue");
`endif

endmodule

@@ sv/nrtc_back.sv @@
module nrtc_back import nrtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [HOUR_W-1:0] cfg_wr_data,
    input  logic              q_not_empty,
    input  line_rec_t         q_rec,
    output logic              q_pop,
    nrtc_result_if.source     result
);

    localparam logic [7:0]       DAY_HOURS  = 8'd24;
    localparam logic [13:0]      RECIP_24   = 14'd43;
    localparam logic [6:0]       MAX_MINSEC = 7'd59;

    logic [HOUR_W-1:0]   offset_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                have_reg;
    logic [HOUR_W-1:0]   held_h_reg, held_h_next;
    logic [MIN_W-1:0]    held_m_reg, held_m_next;
    logic [MIN_W-1:0]    held_s_reg, held_s_next;

    logic [DIGIT_W-1:0]  d [NUM_DIGITS];
    logic [7:0]          h_raw;
    logic [13:0]         h_prod;
    logic [2:0]          h_quot;
    logic [7:0]          h_q24;
    logic [7:0]          h_rem;
    logic [6:0]          m_raw;
    logic [6:0]          s_raw;

    assign q_pop = q_not_empty && (!out_valid_reg || result.ready);

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            d[k] = q_rec.digits[DIGIT_W*k +: DIGIT_W];
        end

        // hour mod 24 by reciprocal multiply, then one corrective subtract
        h_raw  = (8'(d[0]) << 3) + (8'(d[0]) << 1) + 8'(d[1]) + 8'(offset_reg);
        h_prod = 14'(h_raw) * RECIP_24;
        h_quot = h_prod[12:10];
        h_q24  = (8'(h_quot) << 4) + (8'(h_quot) << 3);
        h_rem  = h_raw - h_q24;
        if (h_rem >= DAY_HOURS)
        begin
            h_rem = h_rem - DAY_HOURS;
        end

        m_raw = (7'(d[2]) << 3) + (7'(d[2]) << 1) + 7'(d[3]);
        s_raw = (7'(d[4]) << 3) + (7'(d[4]) << 1) + 7'(d[5]);

        held_h_next = h_rem[HOUR_W-1:0];
        held_m_next = (m_raw > MAX_MINSEC) ? MIN_W'(MAX_MINSEC) : m_raw[MIN_W-1:0];
        held_s_next = (s_raw > MAX_MINSEC) ? MIN_W'(MAX_MINSEC) : s_raw[MIN_W-1:0];
    end

    assign result.valid       = out_valid_reg;
    assign result.line_status = out_status_reg;
    assign result.have_time   = have_reg;
    assign result.hours       = held_h_reg;
    assign result.minutes     = held_m_reg;
    assign result.seconds     = held_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= HOUR_OFFSET_RST;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    // Load the output beat and, on an accepted line, the held time together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            have_reg       <= 1'b0;
            held_h_reg     <= '0;
            held_m_reg     <= '0;
            held_s_reg     <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= q_rec.status;
                if (q_rec.status == ST_OK)
                begin
                    have_reg   <= 1'b1;
                    held_h_reg <= held_h_next;
                    held_m_reg <= held_m_next;
                    held_s_reg <= held_s_next;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_h_reg < HOUR_W'(DAY_HOURS))
        else $error("held hour out of range");
    a_minsec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (held_m_reg <= MIN_W'(MAX_MINSEC)) && (held_s_reg <= MIN_W'(MAX_MINSEC)))
        else $error("held minute or second out of range");
    a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(have_reg))
        else $error("have_time dropped without reset");
`endif

endmodule
